/* rtl/core/led_pattern_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// led pattern sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define LED_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define LPS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lps_pkg.sv */
// ----------------------------------------------------------------------------
// lps_pkg
// Types and fixed field widths of the led pattern sequencer.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int CMD_W   = 2;
  localparam int LEVEL_W = 8;
  localparam int DUR_W   = 8;
  localparam int OFS_W   = 4;
  localparam int PEND_W  = 4;
  localparam int TIMER_W = 12;

  typedef enum logic [CMD_W-1:0] {
    LPS_CMD_TICK   = 2'd0,
    LPS_CMD_APPEND = 2'd1,
    LPS_CMD_LOOP   = 2'd2,
    LPS_CMD_STOP   = 2'd3
  } lps_cmd_e;

  typedef enum logic {
    LPS_IDLE = 1'b0,
    LPS_LOAD = 1'b1
  } lps_state_e;

  typedef struct packed {
    logic apply;
    logic load;
  } lps_ctrl_t;

  typedef struct packed {
    logic fetch_needed;
  } lps_stat_t;

endpackage

/* rtl/core/led_pattern_sequencer_core.sv */
// ----------------------------------------------------------------------------
// led_pattern_sequencer_core
// LED brightness sequencer playing a ring of (level, duration) steps.
// ----------------------------------------------------------------------------
// One input word gives one result word. Append, set-loop-point, stop and
// ticks that only count the step timer apply at once; a tick that starts
// the next step passes the load state, as the step ring is read through a
// registered port. A result waits in the output register while the next word
// is taken, provided the output side takes the waiting word in that same cycle.
module led_pattern_sequencer_core #(
  parameter int RING_DEPTH     = 16,
  parameter int TICKS_PER_UNIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,  // step_level, step_duration, loop_offset, zero pad
  input  logic [1:0]  s_axis_tuser_i,  // command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // led_level, pending_steps, zero pad
);

  lps_pkg::lps_ctrl_t ctrl;
  lps_pkg::lps_stat_t stat;

  logic [lps_pkg::LEVEL_W-1:0] led_level;
  logic [lps_pkg::PEND_W-1:0]  pending_steps;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  lps_dp #(
    .RING_DEPTH     (RING_DEPTH),
    .TICKS_PER_UNIT (TICKS_PER_UNIT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (s_axis_tuser_i),
    .step_level_i    (s_axis_tdata_i[7:0]),
    .step_duration_i (s_axis_tdata_i[15:8]),
    .loop_offset_i   (s_axis_tdata_i[19:16]),
    .led_level_o     (led_level),
    .pending_steps_o (pending_steps)
  );

  assign m_axis_tdata_o = {4'b0000, pending_steps, led_level};

endmodule

/* rtl/core/lps_ctrl.sv */
// ----------------------------------------------------------------------------
// lps_ctrl
// Handshake control and step-fetch sequencing of the led pattern sequencer.
// ----------------------------------------------------------------------------
`include "led_pattern_sequencer_core_assert.svh"

module lps_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  input  lps_pkg::lps_stat_t stat_i,
  output lps_pkg::lps_ctrl_t ctrl_o
);

  lps_pkg::lps_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lps_pkg::LPS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lps_pkg::LPS_IDLE: begin
        if (accept && stat_i.fetch_needed) begin
          state_d = lps_pkg::LPS_LOAD;
        end
      end
      lps_pkg::LPS_LOAD: begin
        state_d = lps_pkg::LPS_IDLE;
      end
      default: begin
        state_d = lps_pkg::LPS_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready_o   = (state_q == lps_pkg::LPS_IDLE) && (!out_valid_q || m_tready_i);
    accept       = s_tready_o && s_tvalid_i;
    ctrl_o.apply = accept && !stat_i.fetch_needed;
    ctrl_o.load  = (state_q == lps_pkg::LPS_LOAD);
    if (ctrl_o.apply || ctrl_o.load) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign m_tvalid_o = out_valid_q;

  `LPS_ASSERT_NEXT(a_fetch_enters_load, accept && stat_i.fetch_needed,
                   state_q == lps_pkg::LPS_LOAD && !out_valid_q, "fetch did not enter load")
  `LPS_ASSERT_IMPL(a_load_output_free, state_q == lps_pkg::LPS_LOAD, !out_valid_q,
                   "output word occupied during load")
  `LPS_ASSERT_NEXT(a_result_presented, ctrl_o.apply || ctrl_o.load, out_valid_q,
                   "result word not presented")

endmodule

/* rtl/core/lps_dp.sv */
// ----------------------------------------------------------------------------
// lps_dp
// Step ring, pointers, step timer and result word register.
// ----------------------------------------------------------------------------
`include "led_pattern_sequencer_core_assert.svh"

module lps_dp #(
  parameter int RING_DEPTH     = 16,
  parameter int TICKS_PER_UNIT = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lps_pkg::lps_ctrl_t            ctrl_i,
  output lps_pkg::lps_stat_t            stat_o,
  input  logic [lps_pkg::CMD_W-1:0]     command_i,
  input  logic [lps_pkg::LEVEL_W-1:0]   step_level_i,
  input  logic [lps_pkg::DUR_W-1:0]     step_duration_i,
  input  logic [lps_pkg::OFS_W-1:0]     loop_offset_i,
  output logic [lps_pkg::LEVEL_W-1:0]   led_level_o,
  output logic [lps_pkg::PEND_W-1:0]    pending_steps_o
);

  localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int SUM_W  = ((PTR_W > lps_pkg::OFS_W) ? PTR_W : lps_pkg::OFS_W) + 1;
  localparam int PEXT_W = (PTR_W > lps_pkg::PEND_W) ? PTR_W : lps_pkg::PEND_W;
  localparam int ENT_W  = lps_pkg::LEVEL_W + lps_pkg::DUR_W;
  localparam int PROD_W = lps_pkg::DUR_W + 5;

  localparam logic [PTR_W-1:0] PtrLast  = PTR_W'(RING_DEPTH - 1);
  localparam logic [SUM_W-1:0] DepthSum = SUM_W'(RING_DEPTH);
  localparam logic [PTR_W:0]   DepthExt = (PTR_W + 1)'(RING_DEPTH);

  logic [ENT_W-1:0]            ring_mem [RING_DEPTH];
  logic [ENT_W-1:0]            rd_q;

  logic [PTR_W-1:0]            rp_q, rp_d, wp_q, wp_d, lp_q, lp_d;
  logic [lps_pkg::TIMER_W-1:0] timer_q, timer_d;
  logic [lps_pkg::LEVEL_W-1:0] level_q, level_d;
  logic [lps_pkg::LEVEL_W-1:0] led_q;
  logic [lps_pkg::PEND_W-1:0]  pend_q;

  logic [lps_pkg::TIMER_W-1:0] timer_dec;
  logic [SUM_W-1:0]            ofs_mod, loop_sum;
  logic [PTR_W:0]              pend_diff;
  logic [PEXT_W-1:0]           pend_ext;
  logic [PROD_W-1:0]           prod;
  logic                        is_tick, is_append, is_loop, is_stop;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    if (p == PtrLast) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign is_tick   = (command_i == lps_pkg::LPS_CMD_TICK);
  assign is_append = (command_i == lps_pkg::LPS_CMD_APPEND);
  assign is_loop   = (command_i == lps_pkg::LPS_CMD_LOOP);
  assign is_stop   = (command_i == lps_pkg::LPS_CMD_STOP);

  assign stat_o.fetch_needed = is_tick && (timer_q == '0) && (wp_q != rp_q);

  // ring write and registered read at the read pointer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply && is_append) begin
      ring_mem[wp_q] <= {step_duration_i, step_level_i};
    end
    rd_q <= ring_mem[rp_q];
  end

  // offset reduced modulo the ring depth, then added to the write pointer
  always_comb begin
    ofs_mod = SUM_W'(loop_offset_i);
    for (int i = 0; i < 8; i++) begin
      if (ofs_mod >= DepthSum) begin
        ofs_mod = ofs_mod - DepthSum;
      end
    end
    loop_sum = SUM_W'(wp_q) + ofs_mod;
    if (loop_sum >= DepthSum) begin
      loop_sum = loop_sum - DepthSum;
    end
  end

  assign timer_dec = timer_q - 1'b1;
  assign prod      = PROD_W'(TICKS_PER_UNIT) * PROD_W'(rd_q[ENT_W-1:lps_pkg::LEVEL_W]);

  always_comb begin
    rp_d    = rp_q;
    wp_d    = wp_q;
    lp_d    = lp_q;
    timer_d = timer_q;
    level_d = level_q;
    if (ctrl_i.load) begin
      level_d = rd_q[lps_pkg::LEVEL_W-1:0];
      timer_d = prod[lps_pkg::TIMER_W-1:0];
      rp_d    = ring_next(rp_q);
    end else if (ctrl_i.apply) begin
      if (is_tick) begin
        if (timer_q != '0) begin
          timer_d = timer_dec;
          if ((timer_dec == '0) && (wp_q == rp_q) && (lp_q != rp_q)) begin
            rp_d = lp_q;
          end
        end
      end else if (is_append) begin
        wp_d = ring_next(wp_q);
      end else if (is_loop) begin
        lp_d = loop_sum[PTR_W-1:0];
      end else if (is_stop) begin
        timer_d = '0;
        rp_d    = '0;
        wp_d    = '0;
        lp_d    = '0;
        level_d = step_level_i;
      end
    end
  end

  // pending count from the updated pointers
  always_comb begin
    pend_diff = {1'b0, wp_d} - {1'b0, rp_d};
    if (pend_diff[PTR_W]) begin
      pend_diff = pend_diff + DepthExt;
    end
    pend_ext = PEXT_W'(pend_diff[PTR_W-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q    <= '0;
      wp_q    <= '0;
      lp_q    <= '0;
      timer_q <= '0;
      level_q <= '0;
    end else begin
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      lp_q    <= lp_d;
      timer_q <= timer_d;
      level_q <= level_d;
    end
  end

  // result word payload
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply || ctrl_i.load) begin
      led_q  <= level_d;
      pend_q <= pend_ext[lps_pkg::PEND_W-1:0];
    end
  end

  assign led_level_o     = led_q;
  assign pending_steps_o = pend_q;

  `LPS_ASSERT_NEXT(a_stop_clears, ctrl_i.apply && is_stop,
                   timer_q == '0 && rp_q == '0 && wp_q == '0 && lp_q == '0,
                   "stop did not clear pointers and timer")
  `LPS_ASSERT_IMPL(a_ptr_range, 1'b1,
                   {1'b0, rp_q} < DepthExt && {1'b0, wp_q} < DepthExt &&
                   {1'b0, lp_q} < DepthExt, "pointer beyond ring depth")

endmodule

/* tb/led_pattern_sequencer_checker.sv */
// ----------------------------------------------------------------------------
// led_pattern_sequencer_checker
// Watches both stream channels of the led pattern sequencer, plays every
// accepted command word through its own copy of the step ring, pointers and
// timer, and compares each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_checker #(
  parameter int TICKS_PER_UNIT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,   // step_level, step_duration, loop_offset, zero pad
  input  logic [1:0]  s_tuser_i,   // command
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // led_level, pending_steps, zero pad
  output int unsigned error_count_o,
  output int unsigned words_due_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lps_pkg::LEVEL_W-1:0] level;
    logic [lps_pkg::PEND_W-1:0]  pending;
  } led_word_t;

  led_word_t                   expected_words[$];
  logic [lps_pkg::LEVEL_W-1:0] ring_level[16];
  logic [lps_pkg::DUR_W-1:0]   ring_dur[16];
  logic [3:0]                  rd_ptr     = '0;
  logic [3:0]                  wr_ptr     = '0;
  logic [3:0]                  loop_ptr   = '0;
  logic [lps_pkg::TIMER_W-1:0] step_timer = '0;
  logic [lps_pkg::LEVEL_W-1:0] cur_level  = '0;
  int unsigned                 error_count = 0;
  int unsigned                 words_due   = 0;

  assign error_count_o = error_count;
  assign words_due_o   = words_due;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic led_word_t play_command(lps_pkg::lps_cmd_e cmd,
                                             logic [lps_pkg::LEVEL_W-1:0] lvl,
                                             logic [lps_pkg::DUR_W-1:0] dur,
                                             logic [lps_pkg::OFS_W-1:0] ofs);
    led_word_t w;
    case (cmd)
      lps_pkg::LPS_CMD_TICK: begin
        if (step_timer != '0) begin
          step_timer = step_timer - 12'd1;
          if (step_timer == '0 && wr_ptr == rd_ptr && loop_ptr != rd_ptr) rd_ptr = loop_ptr;
        end else if (wr_ptr != rd_ptr) begin
          cur_level  = ring_level[rd_ptr];
          step_timer = (lps_pkg::TIMER_W)'(TICKS_PER_UNIT * int'(ring_dur[rd_ptr]));
          rd_ptr     = rd_ptr + 4'd1;
        end
      end
      lps_pkg::LPS_CMD_APPEND: begin
        ring_level[wr_ptr] = lvl;
        ring_dur[wr_ptr]   = dur;
        wr_ptr             = wr_ptr + 4'd1;
      end
      lps_pkg::LPS_CMD_LOOP: begin
        loop_ptr = wr_ptr + ofs;
      end
      default: begin
        step_timer = '0;
        rd_ptr     = '0;
        wr_ptr     = '0;
        loop_ptr   = '0;
        cur_level  = lvl;
      end
    endcase
    w.level   = cur_level;
    w.pending = wr_ptr - rd_ptr;
    return w;
  endfunction

  always @(posedge clk_i) begin : watch
    led_word_t want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i)
        expected_words.push_back(play_command(lps_pkg::lps_cmd_e'(s_tuser_i),
                                              s_tdata_i[7:0], s_tdata_i[15:8],
                                              s_tdata_i[19:16]));
      if (m_tvalid_i && m_tready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", int'(m_tdata_i), 0);
        end else begin
          want = expected_words.pop_front();
          if (m_tdata_i[7:0] !== want.level)
            report_mismatch("led_level", int'(m_tdata_i[7:0]), int'(want.level));
          if (m_tdata_i[11:8] !== want.pending)
            report_mismatch("pending_steps", int'(m_tdata_i[11:8]), int'(want.pending));
          if (m_tdata_i[15:12] !== 4'h0)
            report_mismatch("pad bits", int'(m_tdata_i[15:12]), 0);
        end
      end
      words_due = expected_words.size();
    end
  end

endmodule

/* tb/tb_led_pattern_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_core
// Drives command words into the led pattern sequencer: a directed opening
// that fills the whole ring and hits the field extremes, then random step
// patterns (cyclic, one-shot, zero-length steps, overflow) mixed with noise,
// under several idling phases and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_led_pattern_sequencer_core;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int          ITEMS       = 750;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  int unsigned error_count;
  int unsigned words_due;
  int unsigned cycle_count    = 0;
  int          words_sent     = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  bit          hold_request   = 1'b0;

  led_pattern_sequencer_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  led_pattern_sequencer_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .error_count_o (error_count),
    .words_due_o   (words_due)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request && rst_ni) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_word(lps_pkg::lps_cmd_e cmd, logic [7:0] lvl, logic [7:0] dur,
                           logic [3:0] ofs);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, ofs, dur, lvl};
    s_tuser  <= cmd;
    do @(posedge clk_i); while (!s_tready);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(lps_pkg::LPS_CMD_TICK, 8'($urandom), 8'($urandom), 4'($urandom));
  endtask

  function automatic logic [7:0] pick_duration();
    if ($urandom_range(15) == 0) return 8'($urandom);
    return 8'($urandom_range(2));
  endfunction

  // stop, a loop point before or after a few steps, then a run of ticks to play them
  task automatic send_pattern();
    int n_steps;
    int mode;
    int n_ticks;
    n_steps = $urandom_range(1, 6);
    mode    = $urandom_range(3);
    n_ticks = $urandom_range(10, 60);
    send_word(lps_pkg::LPS_CMD_STOP, 8'($urandom), 8'($urandom), 4'($urandom));
    case (mode)
      0: send_word(lps_pkg::LPS_CMD_LOOP, 8'($urandom), 8'($urandom), 4'd0);
      1: send_word(lps_pkg::LPS_CMD_LOOP, 8'($urandom), 8'($urandom), 4'(n_steps));
      2: send_word(lps_pkg::LPS_CMD_LOOP, 8'($urandom), 8'($urandom), 4'($urandom));
      default: ;
    endcase
    for (int i = 0; i < n_steps; i++) begin
      send_word(lps_pkg::LPS_CMD_APPEND, 8'($urandom), pick_duration(), 4'($urandom));
      if ($urandom_range(3) == 0) send_tick();
    end
    if (mode == 3) begin
      send_word(lps_pkg::LPS_CMD_LOOP, 8'($urandom), 8'($urandom), 4'($urandom));
    end
    repeat (n_ticks) send_tick();
  endtask

  task automatic send_noise();
    lps_pkg::lps_cmd_e cmd;
    repeat (8) begin
      cmd = ($urandom_range(1) == 0) ? lps_pkg::LPS_CMD_TICK
                                     : lps_pkg::lps_cmd_e'($urandom_range(3));
      send_word(cmd, 8'($urandom), pick_duration(), 4'($urandom));
    end
  endtask

  task automatic run_random(int target);
    while (words_sent < target) begin
      if ($urandom_range(99) < 75) send_pattern();
      else send_noise();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every ring entry, wrapping the write pointer
    for (int i = 0; i < 16; i++) begin
      send_word(lps_pkg::LPS_CMD_APPEND,
                (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                (i == 2) ? 8'h00 : (i == 3) ? 8'hFF : 8'($urandom_range(1, 3)),
                4'($urandom));
    end
    send_tick();
    send_word(lps_pkg::LPS_CMD_STOP, 8'hFF, 8'h00, 4'h0);
    send_word(lps_pkg::LPS_CMD_LOOP, 8'h00, 8'hFF, 4'hF);
    send_word(lps_pkg::LPS_CMD_STOP, 8'h00, 8'hFF, 4'hF);
    send_word(lps_pkg::LPS_CMD_APPEND, 8'hA5, 8'h01, 4'h0);
    send_word(lps_pkg::LPS_CMD_APPEND, 8'h5A, 8'h00, 4'h0);
    send_word(lps_pkg::LPS_CMD_LOOP, 8'h00, 8'h00, 4'h0);
    repeat (4) send_tick();

    hold_request = 1'b1;
    run_random(words_sent + ITEMS / 4);
    send_gap_pct = 81;
    run_random(words_sent + ITEMS / 4);
    send_gap_pct   = 0;
    recv_stall_pct = 81;
    run_random(words_sent + ITEMS / 4);
    send_gap_pct   = 31;
    recv_stall_pct = 31;
    run_random(words_sent + ITEMS / 4);

    s_tvalid       <= 1'b0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    while (words_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && words_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lps_pkg.sv
rtl/core/lps_ctrl.sv
rtl/core/lps_dp.sv
rtl/core/led_pattern_sequencer_core.sv
tb/led_pattern_sequencer_checker.sv
tb/tb_led_pattern_sequencer_core.sv
